>>> design/kmd_pkg.sv
// shared constants and types for the key matrix debouncer
`timescale 1ns / 1ps
`default_nettype none

package kmd_pkg;

  // default geometry
  localparam int KEY_COUNT_DEF   = 16;
  localparam int HISTORY_LEN_DEF = 8;

  // fixed widths of the port fields
  localparam int MASK_W    = 16;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int TIMER_W   = 8;
  localparam int STARTUP_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_RELOAD  = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] SAMPLE_LIMIT_RST = 8'd20;
  localparam logic [CFG_W-1:0] DECAY_LIMIT_RST  = 8'd61;
  localparam logic [CFG_W-1:0] HOLD_RELOAD_RST  = 8'hFF;

  // start-up sample count: ready on the eighth sample, then parked at 9
  localparam logic [STARTUP_W-1:0] READY_PREV  = 4'd7;
  localparam logic [STARTUP_W-1:0] READY_PARK  = 4'd9;

  // per-tick controls handed to the key update unit
  typedef struct packed {
    logic               sample;
    logic               dec;
    logic               level;
    logic [TIMER_W-1:0] reload;
  } kmd_step_ctrl_t;

endpackage

`default_nettype wire

>>> design/kmd_divider.sv
// tick divider: fires once every limit plus two ticks
`timescale 1ns / 1ps
`default_nettype none

module kmd_divider
  import kmd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [CFG_W-1:0] limit,
  output logic                  fire
);

  logic [CFG_W-1:0] count;

  // fires when the count has passed the limit
  assign fire = (count > limit);

  // count advances on each tick, restarts on firing
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (step) begin
      if (fire) begin
        count <= '0;
      end else begin
        count <= count + CFG_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/kmd_key_unit.sv
// shared key update unit: one key's history, hold timer and state per use
`timescale 1ns / 1ps
`default_nettype none

module kmd_key_unit
  import kmd_pkg::*;
#(
  parameter int HISTORY_LEN = HISTORY_LEN_DEF
) (
  input  wire kmd_step_ctrl_t         ctrl,
  input  wire logic [HISTORY_LEN-1:0] hist_in,
  input  wire logic [TIMER_W-1:0]     timer_in,
  input  wire logic                   on_in,
  input  wire logic                   flap_in,
  output logic      [HISTORY_LEN-1:0] hist_out,
  output logic      [TIMER_W-1:0]     timer_out,
  output logic                        on_out,
  output logic                        flap_out,
  output logic                        changed
);

  logic [TIMER_W-1:0]     timer_dec;
  logic [HISTORY_LEN-1:0] hist_shift;
  logic                   turn;

  always_comb begin
    // decrement comes ahead of the sample
    timer_dec = timer_in;
    if (ctrl.dec && (timer_in != '0)) begin
      timer_dec = timer_in - TIMER_W'(1);
    end
    hist_shift = {hist_in[HISTORY_LEN-2:0], ctrl.level};
    turn = ctrl.sample &&
           (((hist_shift == '0) && on_in) || ((&hist_shift) && !on_in));

    // apply the change, if any
    hist_out  = ctrl.sample ? hist_shift : hist_in;
    on_out    = turn ? !on_in : on_in;
    flap_out  = turn ? (timer_dec != '0) : flap_in;
    timer_out = turn ? ctrl.reload : timer_dec;
    changed   = turn;
  end

endmodule

`default_nettype wire

>>> design/key_matrix_debouncer.sv
// Shift-register debouncer for a matrix of keys, one timer tick per input
// beat. In: in_valid/in_stall with raw_levels (bit k = key k). Out:
// out_valid/out_stall with changed, pressed and flap masks, key_event,
// sample_taken and history_ready. Config: cfg_write/cfg_index/cfg_data,
// index 0 sample divider limit, 1 decay divider limit, 2 hold reload.
// Each tick advances both dividers, then a sequencer walks the keys one
// per cycle through a single shared update unit, with history and hold
// timer held in a one-port-read memory (registered read, one key ahead).
// out_valid rises once the sweep has updated every key and the result
// has passed from the emit state into the output register; the next beat
// is taken only after that, so beats never overlap.
// in_stall is high from acceptance until the result is in the output
// register; a stalled output holds its beat and the block waits with the
// finished result in the emit state until the register frees up.
// Reset (rst, synchronous) clears dividers, key states, the start-up count
// and the per-entry valid bits, so every key reads as zero history and
// zero timer with no clearing pass; registers return to 20, 61 and 255.
`timescale 1ns / 1ps
`default_nettype none

module key_matrix_debouncer
  import kmd_pkg::*;
#(
  parameter int KEY_COUNT   = KEY_COUNT_DEF,
  parameter int HISTORY_LEN = HISTORY_LEN_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [MASK_W-1:0]    raw_levels,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [MASK_W-1:0]    changed_mask,
  output logic      [MASK_W-1:0]    pressed_mask,
  output logic      [MASK_W-1:0]    flap_mask,
  output logic                      key_event,
  output logic                      sample_taken,
  output logic                      history_ready
);

  localparam int IDX_W   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int ENTRY_W = HISTORY_LEN + TIMER_W;
  localparam logic [IDX_W-1:0] LAST_KEY = IDX_W'(KEY_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_EMIT = 3'b100
  } seq_state_t;

  seq_state_t state;

  logic [CFG_W-1:0] sample_limit;
  logic [CFG_W-1:0] decay_limit;
  logic [CFG_W-1:0] hold_reload;

  logic in_take;
  logic out_load;
  logic sample_fire;
  logic decay_fire;

  logic [STARTUP_W-1:0] startup_samples;
  logic                 sample_ev;
  logic                 dec_ev;
  logic                 ready_ev;
  logic [KEY_COUNT-1:0] level_in;
  logic [KEY_COUNT-1:0] levels;

  logic [ENTRY_W-1:0]   mem [KEY_COUNT];
  logic [KEY_COUNT-1:0] ent_valid;
  logic [ENTRY_W-1:0]   rd_data;
  logic                 rd_ok;
  logic [IDX_W-1:0]     rd_idx;
  logic                 issue_on;
  logic [IDX_W-1:0]     proc_idx;
  logic                 proc_live;

  logic [KEY_COUNT-1:0] key_on;
  logic [KEY_COUNT-1:0] key_flap;
  logic [KEY_COUNT-1:0] changed;

  kmd_step_ctrl_t         unit_ctrl;
  logic [HISTORY_LEN-1:0] hist_cur;
  logic [TIMER_W-1:0]     timer_cur;
  logic [HISTORY_LEN-1:0] hist_new;
  logic [TIMER_W-1:0]     timer_new;
  logic                   on_new;
  logic                   flap_new;
  logic                   unit_changed;

  logic [MASK_W-1:0] changed_w;
  logic [MASK_W-1:0] pressed_w;
  logic [MASK_W-1:0] flap_w;

  // handshakes
  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_load = (state == ST_EMIT) && (!out_valid || !out_stall);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_limit <= SAMPLE_LIMIT_RST;
      decay_limit  <= DECAY_LIMIT_RST;
      hold_reload  <= HOLD_RELOAD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SAMPLE_LIMIT: sample_limit <= cfg_data;
        REG_DECAY_LIMIT:  decay_limit  <= cfg_data;
        REG_HOLD_RELOAD:  hold_reload  <= cfg_data;
        default: ;
      endcase
    end
  end

  // tick dividers
  kmd_divider u_sample_div (
    .clk   (clk),
    .rst   (rst),
    .step  (in_take),
    .limit (sample_limit),
    .fire  (sample_fire)
  );

  kmd_divider u_decay_div (
    .clk   (clk),
    .rst   (rst),
    .step  (in_take),
    .limit (decay_limit),
    .fire  (decay_fire)
  );

  // raw levels spread over the keys, keys past the mask width read low
  for (genvar g = 0; g < KEY_COUNT; g++) begin : g_level
    if (g < MASK_W) begin : g_in
      assign level_in[g] = raw_levels[g];
    end else begin : g_zero
      assign level_in[g] = 1'b0;
    end
  end

  // per-tick events and start-up sample count
  always_ff @(posedge clk) begin
    if (rst) begin
      startup_samples <= '0;
      sample_ev       <= 1'b0;
      dec_ev          <= 1'b0;
      ready_ev        <= 1'b0;
    end else if (in_take) begin
      sample_ev <= sample_fire;
      dec_ev    <= decay_fire;
      ready_ev  <= 1'b0;
      if (sample_fire) begin
        if (startup_samples == READY_PREV) begin
          startup_samples <= READY_PARK;
          ready_ev        <= 1'b1;
        end else if (startup_samples < READY_PREV) begin
          startup_samples <= startup_samples + STARTUP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      levels <= level_in;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issue_on  <= 1'b0;
      proc_live <= 1'b0;
      rd_idx    <= '0;
      proc_idx  <= '0;
    end else begin
      proc_live <= issue_on;
      proc_idx  <= rd_idx;
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            state    <= ST_RUN;
            issue_on <= 1'b1;
            rd_idx   <= '0;
          end
        end
        ST_RUN: begin
          if (issue_on) begin
            if (rd_idx == LAST_KEY) begin
              issue_on <= 1'b0;
            end else begin
              rd_idx <= rd_idx + IDX_W'(1);
            end
          end
          if (proc_live && (proc_idx == LAST_KEY)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // key store: registered read one key ahead of the update
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_idx];
    if (proc_live) begin
      mem[proc_idx] <= {hist_new, timer_new};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      rd_ok <= ent_valid[rd_idx];
      if (proc_live) begin
        ent_valid[proc_idx] <= 1'b1;
      end
    end
  end

  // entries never written read as zero
  assign hist_cur  = rd_ok ? rd_data[ENTRY_W-1:TIMER_W] : '0;
  assign timer_cur = rd_ok ? rd_data[TIMER_W-1:0] : '0;

  assign unit_ctrl.sample = sample_ev;
  assign unit_ctrl.dec    = dec_ev;
  assign unit_ctrl.level  = levels[proc_idx];
  assign unit_ctrl.reload = hold_reload;

  kmd_key_unit #(
    .HISTORY_LEN (HISTORY_LEN)
  ) u_key_unit (
    .ctrl      (unit_ctrl),
    .hist_in   (hist_cur),
    .timer_in  (timer_cur),
    .on_in     (key_on[proc_idx]),
    .flap_in   (key_flap[proc_idx]),
    .hist_out  (hist_new),
    .timer_out (timer_new),
    .on_out    (on_new),
    .flap_out  (flap_new),
    .changed   (unit_changed)
  );

  // debounced state, flap and change bits
  always_ff @(posedge clk) begin
    if (rst) begin
      key_on   <= '0;
      key_flap <= '0;
      changed  <= '0;
    end else begin
      if (in_take) begin
        changed <= '0;
      end
      if (proc_live) begin
        key_on[proc_idx]   <= on_new;
        key_flap[proc_idx] <= flap_new;
        changed[proc_idx]  <= unit_changed;
      end
    end
  end

  // output masks, keys past the mask width left out
  for (genvar g = 0; g < MASK_W; g++) begin : g_mask
    if (g < KEY_COUNT) begin : g_key
      assign changed_w[g] = changed[g];
      assign pressed_w[g] = key_on[g];
      assign flap_w[g]    = key_flap[g];
    end else begin : g_none
      assign changed_w[g] = 1'b0;
      assign pressed_w[g] = 1'b0;
      assign flap_w[g]    = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      changed_mask  <= changed_w;
      pressed_mask  <= pressed_w;
      flap_mask     <= flap_w;
      key_event     <= (changed_w != '0);
      sample_taken  <= sample_ev;
      history_ready <= ready_ev;
    end
  end

endmodule

`default_nettype wire

>>> design/kmd_checker.sv
// port-level checks for the key matrix debouncer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module kmd_checker
  import kmd_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [MASK_W-1:0]    changed_mask,
  input wire logic [MASK_W-1:0]    pressed_mask,
  input wire logic [MASK_W-1:0]    flap_mask,
  input wire logic                 key_event,
  input wire logic                 sample_taken,
  input wire logic                 history_ready
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(changed_mask) &&
      $stable(pressed_mask) && $stable(flap_mask))
    else $error("stalled result beat changed");

  // key event flags a nonzero change mask
  a_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> key_event == (changed_mask != '0))
    else $error("key_event disagrees with changed_mask");

  // no change and no ready pulse without a sample
  a_no_sample: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sample_taken |-> (changed_mask == '0) && !history_ready)
    else $error("change reported on a tick with no sample");

  // a taken beat keeps the block busy for the key sweep
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again straight after a beat");

  // the ready pulse comes once and not on back-to-back results
  a_ready_once: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && history_ready |=> !(out_valid && history_ready))
    else $error("history_ready repeated");

endmodule

bind key_matrix_debouncer kmd_checker u_kmd_checker (.*);

`default_nettype wire

>>> bench/key_matrix_debouncer_checker.sv
// checker for the key matrix debouncer: predicts each tick report and compares it
`timescale 1ns / 1ps

module key_matrix_debouncer_checker
  import kmd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [MASK_W-1:0]    raw_levels,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [MASK_W-1:0]    changed_mask,
  input  logic [MASK_W-1:0]    pressed_mask,
  input  logic [MASK_W-1:0]    flap_mask,
  input  logic                 key_event,
  input  logic                 sample_taken,
  input  logic                 history_ready,
  output int                   mismatches,
  output int                   reports_owed
);

  localparam int KEYS = MASK_W;
  localparam int HIST = HISTORY_LEN_DEF;

  typedef struct packed {
    logic [MASK_W-1:0] changed;
    logic [MASK_W-1:0] pressed;
    logic [MASK_W-1:0] flap;
    logic              key_event;
    logic              sample_taken;
    logic              history_ready;
  } tick_report_t;

  // register copies
  logic [CFG_W-1:0] sample_limit;
  logic [CFG_W-1:0] decay_limit;
  logic [CFG_W-1:0] hold_reload;

  // predicted key state
  logic [HIST-1:0]    history [KEYS];
  logic [TIMER_W-1:0] hold_timer [KEYS];
  logic [KEYS-1:0]    key_on;
  logic [KEYS-1:0]    key_flap;
  logic [CFG_W-1:0]   sample_count;
  logic [CFG_W-1:0]   decay_count;
  logic [STARTUP_W-1:0] startup_count;

  tick_report_t expected_reports [$];

  initial begin
    mismatches = 0;
    reports_owed = 0;
  end

  task automatic clear_debouncer();
    sample_limit = SAMPLE_LIMIT_RST;
    decay_limit = DECAY_LIMIT_RST;
    hold_reload = HOLD_RELOAD_RST;
    for (int k = 0; k < KEYS; k++) begin
      history[k] = '0;
      hold_timer[k] = '0;
    end
    key_on = '0;
    key_flap = '0;
    sample_count = '0;
    decay_count = '0;
    startup_count = '0;
  endtask

  // one timer tick: dividers, start-up count, timer decay, then key sampling
  function automatic tick_report_t debounce_tick(input logic [MASK_W-1:0] levels);
    tick_report_t rep;
    logic dec_now;
    logic sample_now;
    logic [HIST-1:0] h;
    rep = '0;
    dec_now = decay_count > decay_limit;
    decay_count = dec_now ? '0 : decay_count + 8'd1;
    sample_now = sample_count > sample_limit;
    sample_count = sample_now ? '0 : sample_count + 8'd1;
    rep.sample_taken = sample_now;

    // ready fires once, on the eighth sample, then the count parks
    if (sample_now) begin
      if (startup_count == READY_PREV) begin
        rep.history_ready = 1'b1;
        startup_count = READY_PARK;
      end else if (startup_count < READY_PREV) begin
        startup_count = startup_count + 4'd1;
      end
    end

    // decrement comes before the sample on a shared tick
    if (dec_now) begin
      for (int k = 0; k < KEYS; k++)
        if (hold_timer[k] != '0) hold_timer[k] = hold_timer[k] - 8'd1;
    end

    if (sample_now) begin
      for (int k = 0; k < KEYS; k++) begin
        h = {history[k][HIST-2:0], levels[k]};
        history[k] = h;
        if ((h == '0 && key_on[k]) || (h == '1 && !key_on[k])) begin
          key_on[k] = !key_on[k];
          key_flap[k] = hold_timer[k] != '0;
          hold_timer[k] = hold_reload;
          rep.changed[k] = 1'b1;
        end
      end
    end

    rep.pressed = key_on;
    rep.flap = key_flap;
    rep.key_event = |rep.changed;
    return rep;
  endfunction

  // watch the channels and the register port
  always @(posedge clk) begin
    tick_report_t exp_rep;
    if (rst) begin
      clear_debouncer();
      expected_reports.delete();
    end else begin
      // result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("result beat with no tick outstanding");
          mismatches <= mismatches + 1;
        end else begin
          exp_rep = expected_reports.pop_front();
          if ({changed_mask, pressed_mask, flap_mask, key_event, sample_taken,
               history_ready} !== exp_rep)
            mismatches <= mismatches + 1;
          if (changed_mask !== exp_rep.changed)
            $error("changed_mask: expected %h, got %h", exp_rep.changed, changed_mask);
          if (pressed_mask !== exp_rep.pressed)
            $error("pressed_mask: expected %h, got %h", exp_rep.pressed, pressed_mask);
          if (flap_mask !== exp_rep.flap)
            $error("flap_mask: expected %h, got %h", exp_rep.flap, flap_mask);
          if (key_event !== exp_rep.key_event)
            $error("key_event: expected %b, got %b", exp_rep.key_event, key_event);
          if (sample_taken !== exp_rep.sample_taken)
            $error("sample_taken: expected %b, got %b", exp_rep.sample_taken,
                   sample_taken);
          if (history_ready !== exp_rep.history_ready)
            $error("history_ready: expected %b, got %b", exp_rep.history_ready,
                   history_ready);
        end
      end

      // register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_SAMPLE_LIMIT: sample_limit = cfg_data;
          REG_DECAY_LIMIT:  decay_limit = cfg_data;
          REG_HOLD_RELOAD:  hold_reload = cfg_data;
          default: ;
        endcase
      end

      // tick beat
      if (in_valid && !in_stall)
        expected_reports.push_back(debounce_tick(raw_levels));
    end
    reports_owed <= expected_reports.size();
  end

endmodule

>>> bench/key_matrix_debouncer_tb.sv
// testbench top for the key matrix debouncer: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module key_matrix_debouncer_tb;
  import kmd_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_TICKS = 1350;
  localparam int DIRECTED_TICKS = 24;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SAMPLE_LIMIT;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic [MASK_W-1:0]    raw_levels = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic [MASK_W-1:0]    changed_mask;
  logic [MASK_W-1:0]    pressed_mask;
  logic [MASK_W-1:0]    flap_mask;
  logic                 key_event;
  logic                 sample_taken;
  logic                 history_ready;

  int mismatches;
  int reports_owed;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles = 0;
  int ticks_sent = 0;
  logic [CFG_W-1:0]  cur_sample_limit = SAMPLE_LIMIT_RST;
  logic [MASK_W-1:0] levels_now = '0;

  always #6 clk = ~clk;

  key_matrix_debouncer dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .raw_levels(raw_levels),
    .out_valid(out_valid), .out_stall(out_stall),
    .changed_mask(changed_mask), .pressed_mask(pressed_mask), .flap_mask(flap_mask),
    .key_event(key_event), .sample_taken(sample_taken), .history_ready(history_ready)
  );

  key_matrix_debouncer_checker checker_i (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .raw_levels(raw_levels),
    .out_valid(out_valid), .out_stall(out_stall),
    .changed_mask(changed_mask), .pressed_mask(pressed_mask), .flap_mask(flap_mask),
    .key_event(key_event), .sample_taken(sample_taken), .history_ready(history_ready),
    .mismatches(mismatches), .reports_owed(reports_owed)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one tick beat, with random gaps in front; idle mix follows progress
  task automatic send_tick(input logic [MASK_W-1:0] lv);
    if (ticks_sent < 457) begin
      send_idle_pct = 15;
      recv_idle_pct = 64;
    end else if (ticks_sent < 914) begin
      send_idle_pct = 64;
      recv_idle_pct = 15;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_levels <= lv;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  // stop sending and wait for every report to come back
  task automatic drain_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_owed != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // registers change only with the block idle
  task automatic apply_settings(input logic [CFG_W-1:0] s_lim, input logic [CFG_W-1:0] d_lim,
                                input logic [CFG_W-1:0] reload);
    drain_reports();
    write_reg(REG_SAMPLE_LIMIT, s_lim);
    write_reg(REG_DECAY_LIMIT, d_lim);
    write_reg(REG_HOLD_RELOAD, reload);
    cfg_write <= 1'b0;
    cur_sample_limit = s_lim;
  endtask

  // a run of ticks towards a new key pattern, with occasional contact bounce;
  // most runs last long enough to debounce, the rest are cut short
  task automatic send_run(input int max_len);
    logic [MASK_W-1:0] target;
    logic [MASK_W-1:0] lv;
    int span;
    int len;
    span = 8 * (int'(cur_sample_limit) + 2);
    case ($urandom_range(3))
      0: target = MASK_W'($urandom);
      1: target = levels_now ^ (16'h1 << $urandom_range(15));
      2: target = levels_now ^ MASK_W'($urandom);
      default: target = ~levels_now;
    endcase
    if ($urandom_range(3) != 0)
      len = span + $urandom_range(0, 2 * (int'(cur_sample_limit) + 2));
    else
      len = $urandom_range(1, span);
    if (len > 64) len = 64;
    if (len > max_len) len = max_len;
    for (int i = 0; i < len; i++) begin
      lv = target;
      if ($urandom_range(9) == 0) lv = lv ^ (16'h1 << $urandom_range(15));
      send_tick(lv);
    end
    levels_now = target;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] s_lim, input logic [CFG_W-1:0] d_lim,
                           input logic [CFG_W-1:0] reload, input int n);
    int start;
    apply_settings(s_lim, d_lim, reload);
    start = ticks_sent;
    while (ticks_sent - start < n) send_run(n - (ticks_sent - start));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: fastest sampling, all keys on at the eighth sample
    apply_settings(8'd0, 8'd0, 8'd1);
    repeat (16) send_tick(16'hFFFF);
    send_tick(16'h0000);
    send_tick(16'hAAAA);
    send_tick(16'h5555);
    send_tick(16'h0001);
    send_tick(16'h8000);
    // dividers that never fire, zero hold reload
    apply_settings(8'hFF, 8'hFF, 8'h00);
    send_tick(16'hFFFF);
    send_tick(16'h0000);
    send_tick(16'h8001);

    // random phases; lowering a limit below a running count happens between them
    run_phase(8'd0, 8'd253, 8'd255, 160);
    run_phase(8'd1, 8'd0, 8'd1, 140);
    run_phase(8'd253, 8'd0, 8'd128, 40);
    run_phase(8'd0, 8'd5, 8'd20, 140);
    run_phase(8'd255, 8'd255, 8'd255, 30);
    run_phase(8'd2, 8'd1, 8'd8, 120);
    run_phase(8'd0, 8'd3, 8'd0, 140);
    while (ticks_sent < DIRECTED_TICKS + RANDOM_TICKS)
      run_phase(8'($urandom_range(0, 3)), 8'($urandom_range(0, 253)),
                8'($urandom_range(1, 255)), 120);

    drain_reports();
    repeat (KEY_COUNT_DEF + 4) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
